[rtl/assert_macros.svh]
// Assertion macros for the RTL of the grid search core.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[rtl/irrgs_pkg.sv]
// Types and constants of the rate grid search core.
// No dependencies; used by irr_grid_search_core.
`timescale 1ns / 1ps

package irrgs_pkg;

   localparam int MAX_FLOWS_DEF = 64;
   localparam int RATE_W        = 17;
   localparam int FLOW_W        = 48;
   localparam int ABS_W         = 47;
   localparam int ACC_W         = 64;
   localparam int DEN_W         = 18;
   localparam int NUM_W         = 45;
   localparam int DIV_STEPS     = NUM_W;

   localparam logic [DEN_W-1:0] RATE_ONE = DEN_W'(10000);
   // One in Q1.31 times the rate unit count of 1.0.
   localparam logic [NUM_W-1:0] NUM_BASE = NUM_W'(64'd21474836480000);
   localparam logic [ABS_W-1:0] ABS_MAX  = {ABS_W{1'b1}};

   localparam logic [1:0] CSR_RATE_FIRST = 2'd0;
   localparam logic [1:0] CSR_RATE_LAST  = 2'd1;
   localparam logic [1:0] CSR_RATE_STEP  = 2'd2;

   typedef struct packed {
      logic signed [FLOW_W-1:0] cashflow;
      logic                     last;
   } flow_item_type;

   typedef struct packed {
      logic [RATE_W-1:0] best_rate;
      logic [ABS_W-1:0]  best_abs_npv;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_ABS,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_ACC,
      ST_FINAL,
      ST_JUDGE,
      ST_REPORT
   } state_type;

endpackage

[rtl/irr_grid_search_core.sv]
// Rate grid search core: stores cash flows, then scans rates for the smallest |NPV|.
// Depends on irrgs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Ports                           Direction
// request   start, busy, req_data           in, one item when start and not busy
// result    rsp_valid, rsp_data             out, one-cycle strobe
// csr       csr_we, csr_index, csr_wdata    in, write only
//
// Flows load at one item per cycle into the flow memory while idle.
// An item with last set starts the scan; each rate passes SETUP and the bit-serial divider,
// then the Horner loop with ABS, MUL_HI, MUL_LO and ACC per stored flow, then FINAL and JUDGE.
// The result strobes once, registered from REPORT after the last rate is judged; busy is low again then.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall.
module irr_grid_search_core #(
   parameter int MAX_FLOWS = irrgs_pkg::MAX_FLOWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  irrgs_pkg::flow_item_type          req_data,
   output logic                              rsp_valid,
   output irrgs_pkg::result_type             rsp_data,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [irrgs_pkg::RATE_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FLOWS + 1);
   localparam int AW    = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int DC_W  = $clog2(irrgs_pkg::DIV_STEPS);

   irrgs_pkg::state_type state_ff, state_in;

   logic [irrgs_pkg::RATE_W-1:0] rate_first_ff, rate_last_ff, rate_step_ff;
   logic [CNT_W-1:0]             count_ff, t_ff;
   logic [irrgs_pkg::RATE_W-1:0] rate_ff, best_rate_ff;
   logic [irrgs_pkg::ABS_W-1:0]  best_abs_ff;
   logic                         first_ff;
   logic [irrgs_pkg::DEN_W-1:0]  den_ff;
   logic [irrgs_pkg::DEN_W-1:0]  rem_ff;
   logic [irrgs_pkg::NUM_W-1:0]  quo_ff;
   logic [DC_W-1:0]              div_cnt_ff;
   logic [31:0]                  factor_ff;
   logic signed [irrgs_pkg::ACC_W-1:0] acc_ff;
   logic [irrgs_pkg::ACC_W-1:0]  mag_ff, hsum_ff, prod_ff;
   logic                         neg_ff;
   logic signed [irrgs_pkg::FLOW_W-1:0] flow_mem [MAX_FLOWS];
   logic signed [irrgs_pkg::FLOW_W-1:0] rd_ff;
   logic                         rsp_valid_ff;
   irrgs_pkg::result_type        rsp_data_ff;

   logic                         accept;
   logic                         div_done, t_last, rate_more, better;
   logic [irrgs_pkg::DEN_W-1:0]  den_new;
   logic [irrgs_pkg::DEN_W:0]    rem_sh;
   logic [irrgs_pkg::DEN_W:0]    rate_next;
   logic [irrgs_pkg::RATE_W-1:0] step_eff;
   logic [irrgs_pkg::ACC_W-1:0]  res, acc_abs;
   logic signed [irrgs_pkg::ACC_W-1:0] res_signed;
   logic [irrgs_pkg::ABS_W-1:0]  abs_sat;
   logic [CNT_W-1:0]             t_dec;
   logic                         mem_we, mem_re;

   assign accept    = start && (state_ff == irrgs_pkg::ST_IDLE);
   assign busy      = (state_ff != irrgs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign den_new   = irrgs_pkg::RATE_ONE + {1'b0, rate_ff};
   assign rem_sh    = {rem_ff, quo_ff[irrgs_pkg::NUM_W-1]};
   assign div_done  = (div_cnt_ff == DC_W'(irrgs_pkg::DIV_STEPS - 1));
   assign t_dec     = t_ff - CNT_W'(1);
   assign t_last    = (t_dec == '0);
   assign step_eff  = (rate_step_ff == '0) ? irrgs_pkg::RATE_W'(1) : rate_step_ff;
   assign rate_next = {1'b0, rate_ff} + {1'b0, step_eff};
   assign rate_more = (rate_next <= {1'b0, rate_last_ff});
   assign acc_abs   = acc_ff[irrgs_pkg::ACC_W-1] ? (irrgs_pkg::ACC_W'(0) - acc_ff) : acc_ff;
   assign abs_sat   = (mag_ff > {17'd0, irrgs_pkg::ABS_MAX}) ? irrgs_pkg::ABS_MAX
                                                         : mag_ff[irrgs_pkg::ABS_W-1:0];
   assign better    = first_ff || (abs_sat < best_abs_ff);

   // Rounded Q1.31 scale of the magnitude, halves away from zero.
   assign res        = hsum_ff + ((prod_ff + irrgs_pkg::ACC_W'(64'h4000_0000)) >> 31);
   assign res_signed = neg_ff ? (irrgs_pkg::ACC_W'(0) - res) : res;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         irrgs_pkg::ST_IDLE: begin
            if (accept && req_data.last) state_in = irrgs_pkg::ST_SETUP;
         end
         irrgs_pkg::ST_SETUP:  state_in = irrgs_pkg::ST_DIV;
         irrgs_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (count_ff == '0) ? irrgs_pkg::ST_FINAL : irrgs_pkg::ST_ABS;
            end
         end
         irrgs_pkg::ST_ABS:    state_in = irrgs_pkg::ST_MUL_HI;
         irrgs_pkg::ST_MUL_HI: state_in = irrgs_pkg::ST_MUL_LO;
         irrgs_pkg::ST_MUL_LO: state_in = irrgs_pkg::ST_ACC;
         irrgs_pkg::ST_ACC:    state_in = t_last ? irrgs_pkg::ST_FINAL : irrgs_pkg::ST_ABS;
         irrgs_pkg::ST_FINAL:  state_in = irrgs_pkg::ST_JUDGE;
         irrgs_pkg::ST_JUDGE:  state_in = rate_more ? irrgs_pkg::ST_SETUP
                                                    : irrgs_pkg::ST_REPORT;
         irrgs_pkg::ST_REPORT: state_in = irrgs_pkg::ST_IDLE;
         default:              state_in = irrgs_pkg::ST_IDLE;
      endcase
   end

   // Memory controls.
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      unique case (state_ff)
         irrgs_pkg::ST_IDLE: mem_we = accept && (count_ff < CNT_W'(MAX_FLOWS));
         irrgs_pkg::ST_ABS:  mem_re = 1'b1;
         default: begin
            mem_we = 1'b0;
            mem_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) flow_mem[count_ff[AW-1:0]] <= req_data.cashflow;
      if (mem_re) rd_ff <= flow_mem[t_dec[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= irrgs_pkg::ST_IDLE;
         rate_first_ff <= irrgs_pkg::RATE_W'(1);
         rate_last_ff  <= irrgs_pkg::RATE_W'(100000);
         rate_step_ff  <= irrgs_pkg::RATE_W'(1);
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == irrgs_pkg::ST_REPORT);
         if (csr_we) begin
            unique case (csr_index)
               irrgs_pkg::CSR_RATE_FIRST: rate_first_ff <= csr_wdata;
               irrgs_pkg::CSR_RATE_LAST:  rate_last_ff  <= csr_wdata;
               irrgs_pkg::CSR_RATE_STEP:  rate_step_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (mem_we) count_ff <= count_ff + CNT_W'(1);
         if (state_ff == irrgs_pkg::ST_REPORT) count_ff <= '0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         irrgs_pkg::ST_IDLE: begin
            rate_ff  <= rate_first_ff;
            first_ff <= 1'b1;
         end
         irrgs_pkg::ST_SETUP: begin
            den_ff     <= den_new;
            rem_ff     <= '0;
            quo_ff     <= irrgs_pkg::NUM_BASE + irrgs_pkg::NUM_W'(den_new >> 1);
            div_cnt_ff <= '0;
         end
         irrgs_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle.
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= irrgs_pkg::DEN_W'(rem_sh - {1'b0, den_ff});
               quo_ff <= {quo_ff[irrgs_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[irrgs_pkg::DEN_W-1:0];
               quo_ff <= {quo_ff[irrgs_pkg::NUM_W-2:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff + DC_W'(1);
            if (div_done) begin
               factor_ff <= (rem_sh >= {1'b0, den_ff}) ? {quo_ff[30:0], 1'b1}
                                                       : {quo_ff[30:0], 1'b0};
               acc_ff    <= '0;
               t_ff      <= count_ff;
            end
         end
         irrgs_pkg::ST_ABS: begin
            neg_ff <= acc_ff[irrgs_pkg::ACC_W-1];
            mag_ff <= acc_abs;
         end
         irrgs_pkg::ST_MUL_HI: prod_ff <= mag_ff[63:32] * factor_ff;
         irrgs_pkg::ST_MUL_LO: begin
            hsum_ff <= prod_ff << 1;
            prod_ff <= mag_ff[31:0] * factor_ff;
         end
         irrgs_pkg::ST_ACC: begin
            acc_ff <= res_signed + irrgs_pkg::ACC_W'(rd_ff);
            t_ff   <= t_dec;
         end
         irrgs_pkg::ST_FINAL: mag_ff <= acc_abs;
         irrgs_pkg::ST_JUDGE: begin
            if (better) begin
               best_abs_ff  <= abs_sat;
               best_rate_ff <= rate_ff;
            end
            first_ff <= 1'b0;
            rate_ff  <= rate_next[irrgs_pkg::RATE_W-1:0];
         end
         irrgs_pkg::ST_REPORT: begin
            rsp_data_ff.best_rate    <= best_rate_ff;
            rsp_data_ff.best_abs_npv <= best_abs_ff;
         end
         default: ;
      endcase
   end

   `ASSERT_CLK(a_rsp_after_report, rsp_valid |-> $past(state_ff == irrgs_pkg::ST_REPORT),
      "result strobe without a finished scan")
   `ASSERT_CLK(a_rsp_one_cycle, rsp_valid |=> !rsp_valid, "result strobe longer than one cycle")
   `ASSERT_NEVER(a_count_range, count_ff > CNT_W'(MAX_FLOWS), "flow count beyond the store")
   `ASSERT_CLK(a_rem_bound, (state_ff == irrgs_pkg::ST_DIV) |-> (rem_ff < den_ff),
      "divider remainder not below the divisor")

endmodule
